// ===== hdl/page_frame_allocator_macros.svh =====
// Assertion macros used by the checker file.
`ifndef PAGE_FRAME_ALLOCATOR_MACROS_SVH
`define PAGE_FRAME_ALLOCATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/pfa_pkg.sv =====
package pfa_pkg;

  localparam int NumFramesDef    = 16;
  localparam int MaxProcsDef     = 16;
  localparam int PagesPerProcDef = 8;

  // At most eight results per request; the page count register fits that.
  localparam int MaxRes = 8;
  localparam int HeldW  = 4;
  localparam int SlotW  = 3;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FRAMES = 2'd1,
    ST_BAD_REQ   = 2'd2,
    ST_INVALID   = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [3:0] pid;
    logic [3:0] num_pages;
    logic [2:0] page_index;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] frame;
    logic [2:0] page_slot;
    logic [4:0] free_count;
    logic       last;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_ALLOC,
    S_FREE_RD,
    S_FREE_WR,
    S_FREE_DONE,
    S_READ_OUT
  } state_e;

  typedef enum logic [1:0] {
    FRM_ZERO,
    FRM_SCAN,
    FRM_TABLE
  } frame_sel_e;

  typedef enum logic [1:0] {
    SLT_ZERO,
    SLT_COUNT,
    SLT_INDEX
  } slot_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       latch_req;
    logic       load_alloc;
    logic       clear_slot;
    logic       pt_rd;
    logic       pt_rd_idx;
    logic       scan_next;
    logic       take_frame;
    logic       free_frame;
    logic       slot_inc;
    logic       held_wr;
    logic       held_wr_n;
    logic       emit;
    status_e    status;
    frame_sel_e frame_sel;
    slot_sel_e  slot_sel;
    logic       last;
  } pfa_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic req_bad;
    logic is_alloc;
    logic is_free;
    logic alloc_bad;
    logic alloc_short;
    logic held_zero;
    logic idx_bad;
    logic entry_valid;
    logic scan_free;
    logic alloc_last;
    logic free_last;
    logic out_room;
  } pfa_sts_t;

endpackage

// ===== hdl/pfa_req_if.sv =====
interface pfa_req_if;
  logic          valid;
  logic          ready;
  pfa_pkg::req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/pfa_res_if.sv =====
interface pfa_res_if;
  logic          valid;
  logic          ready;
  pfa_pkg::res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/pfa_ctrl.sv =====
module pfa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  pfa_pkg::pfa_sts_t sts_i,
  output pfa_pkg::pfa_ctl_t ctl_o
);
  import pfa_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.req_bad) begin
          if (sts_i.out_room) state_d = S_IDLE;
        end else if (sts_i.is_alloc) begin
          if (sts_i.alloc_bad || sts_i.alloc_short) begin
            if (sts_i.out_room) state_d = S_IDLE;
          end else begin
            state_d = S_ALLOC;
          end
        end else if (sts_i.is_free) begin
          if (!sts_i.held_zero) begin
            state_d = S_FREE_RD;
          end else if (sts_i.out_room) begin
            state_d = S_IDLE;
          end
        end else begin
          if (sts_i.idx_bad || !sts_i.entry_valid) begin
            if (sts_i.out_room) state_d = S_IDLE;
          end else begin
            state_d = S_READ_OUT;
          end
        end
      end
      S_ALLOC: begin
        if (sts_i.scan_free && sts_i.out_room && sts_i.alloc_last) begin
          state_d = S_IDLE;
        end
      end
      S_FREE_RD: begin
        state_d = S_FREE_WR;
      end
      S_FREE_WR: begin
        state_d = sts_i.free_last ? S_FREE_DONE : S_FREE_RD;
      end
      S_FREE_DONE: begin
        if (sts_i.out_room) state_d = S_IDLE;
      end
      S_READ_OUT: begin
        if (sts_i.out_room) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl_o           = '0;
    ctl_o.status    = ST_OK;
    ctl_o.frame_sel = FRM_ZERO;
    ctl_o.slot_sel  = SLT_ZERO;
    req_ready_o     = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o     = 1'b1;
        ctl_o.latch_req = req_valid_i;
      end
      S_CHECK: begin
        ctl_o.last = 1'b1;
        if (sts_i.req_bad) begin
          ctl_o.emit   = sts_i.out_room;
          ctl_o.status = ST_BAD_REQ;
        end else if (sts_i.is_alloc) begin
          if (sts_i.alloc_bad) begin
            ctl_o.emit   = sts_i.out_room;
            ctl_o.status = ST_BAD_REQ;
          end else if (sts_i.alloc_short) begin
            ctl_o.emit   = sts_i.out_room;
            ctl_o.status = ST_NO_FRAMES;
          end else begin
            ctl_o.load_alloc = 1'b1;
          end
        end else if (sts_i.is_free) begin
          if (sts_i.held_zero) begin
            ctl_o.emit = sts_i.out_room;
          end else begin
            ctl_o.clear_slot = 1'b1;
          end
        end else begin
          ctl_o.slot_sel = SLT_INDEX;
          if (sts_i.idx_bad) begin
            ctl_o.emit   = sts_i.out_room;
            ctl_o.status = ST_BAD_REQ;
          end else if (!sts_i.entry_valid) begin
            ctl_o.emit   = sts_i.out_room;
            ctl_o.status = ST_INVALID;
          end else begin
            ctl_o.pt_rd     = 1'b1;
            ctl_o.pt_rd_idx = 1'b1;
          end
        end
      end
      S_ALLOC: begin
        ctl_o.frame_sel = FRM_SCAN;
        ctl_o.slot_sel  = SLT_COUNT;
        ctl_o.last      = sts_i.alloc_last;
        if (sts_i.scan_free) begin
          if (sts_i.out_room) begin
            ctl_o.take_frame = 1'b1;
            ctl_o.scan_next  = 1'b1;
            ctl_o.slot_inc   = 1'b1;
            ctl_o.emit       = 1'b1;
            ctl_o.held_wr    = sts_i.alloc_last;
            ctl_o.held_wr_n  = 1'b1;
          end
        end else begin
          ctl_o.scan_next = 1'b1;
        end
      end
      S_FREE_RD: begin
        ctl_o.pt_rd = 1'b1;
      end
      S_FREE_WR: begin
        ctl_o.free_frame = 1'b1;
        ctl_o.slot_inc   = 1'b1;
      end
      S_FREE_DONE: begin
        ctl_o.last    = 1'b1;
        ctl_o.emit    = sts_i.out_room;
        ctl_o.held_wr = sts_i.out_room;
      end
      S_READ_OUT: begin
        ctl_o.last      = 1'b1;
        ctl_o.frame_sel = FRM_TABLE;
        ctl_o.slot_sel  = SLT_INDEX;
        ctl_o.emit      = sts_i.out_room;
      end
      default: begin
        req_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== hdl/pfa_datapath.sv =====
module pfa_datapath #(
  parameter int NUM_FRAMES     = pfa_pkg::NumFramesDef,
  parameter int MAX_PROCS      = pfa_pkg::MaxProcsDef,
  parameter int PAGES_PER_PROC = pfa_pkg::PagesPerProcDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pfa_pkg::req_t     req_data_i,
  input  pfa_pkg::pfa_ctl_t ctl_i,
  output pfa_pkg::pfa_sts_t sts_o,
  output logic              res_valid_o,
  output pfa_pkg::res_t     res_data_o,
  input  logic              res_ready_i
);
  import pfa_pkg::*;

  localparam int FrameW     = $clog2(NUM_FRAMES);
  localparam int CountW     = $clog2(NUM_FRAMES + 1);
  localparam int ProcW      = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int TableDepth = MAX_PROCS * PAGES_PER_PROC;
  localparam int AddrW      = (TableDepth > 1) ? $clog2(TableDepth) : 1;

  // Request registers.
  logic [1:0]       cmd_q;
  logic [3:0]       pid_q;
  logic [3:0]       num_q;
  logic [2:0]       idx_q;
  logic [ProcW-1:0] pid_idx_q;
  logic [ProcW-1:0] pid_in;

  // Frame bitmap, free count, scan pointer and page slot counter.
  logic [NUM_FRAMES-1:0] free_map_q;
  logic [CountW-1:0]     frees_q;
  logic [FrameW-1:0]     scan_q;
  logic [SlotW-1:0]      slot_q;

  // Pages held per process: memory plus one valid bit per process.
  logic [HeldW-1:0]     held_mem [MAX_PROCS];
  logic [MAX_PROCS-1:0] held_vld_q;
  logic [HeldW-1:0]     held_rd_q;
  logic                 held_rd_vld_q;
  logic [HeldW-1:0]     held_now;

  // Page table: a frame number per slot; validity follows from the page count.
  logic [FrameW-1:0] pt_mem [TableDepth];
  logic [FrameW-1:0] pt_rd_q;
  logic [AddrW-1:0]  pt_wr_addr;
  logic [AddrW-1:0]  pt_rd_addr;

  logic              out_vld_q;
  res_t              out_q;
  logic              out_room;
  logic [3:0]        frame_mux;
  logic [SlotW-1:0]  slot_mux;

  assign pid_in   = ProcW'(req_data_i.pid);
  assign held_now = held_rd_vld_q ? held_rd_q : '0;
  assign out_room = !out_vld_q || res_ready_i;

  assign pt_wr_addr = AddrW'(int'(pid_idx_q) * PAGES_PER_PROC + int'(slot_q));
  assign pt_rd_addr = ctl_i.pt_rd_idx
                    ? AddrW'(int'(pid_idx_q) * PAGES_PER_PROC + int'(idx_q))
                    : pt_wr_addr;

  always_ff @(posedge clk_i) begin
    if (ctl_i.latch_req) begin
      cmd_q         <= req_data_i.cmd;
      pid_q         <= req_data_i.pid;
      num_q         <= req_data_i.num_pages;
      idx_q         <= req_data_i.page_index;
      pid_idx_q     <= pid_in;
      held_rd_q     <= held_mem[pid_in];
      held_rd_vld_q <= held_vld_q[pid_in];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.held_wr) begin
      held_mem[pid_idx_q] <= ctl_i.held_wr_n ? num_q : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.take_frame) begin
      pt_mem[pt_wr_addr] <= scan_q;
    end
    if (ctl_i.pt_rd) begin
      pt_rd_q <= pt_mem[pt_rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_vld_q <= '0;
      free_map_q <= '1;
      frees_q    <= CountW'(NUM_FRAMES);
      scan_q     <= '0;
      slot_q     <= '0;
    end else begin
      if (ctl_i.held_wr) begin
        held_vld_q[pid_idx_q] <= 1'b1;
      end
      if (ctl_i.load_alloc) begin
        frees_q <= frees_q - CountW'(num_q);
      end else if (ctl_i.free_frame && !free_map_q[pt_rd_q]) begin
        frees_q <= frees_q + CountW'(1);
      end
      if (ctl_i.take_frame) begin
        free_map_q[scan_q] <= 1'b0;
      end else if (ctl_i.free_frame) begin
        free_map_q[pt_rd_q] <= 1'b1;
      end
      if (ctl_i.load_alloc) begin
        scan_q <= '0;
      end else if (ctl_i.scan_next) begin
        scan_q <= scan_q + FrameW'(1);
      end
      if (ctl_i.load_alloc || ctl_i.clear_slot) begin
        slot_q <= '0;
      end else if (ctl_i.slot_inc) begin
        slot_q <= slot_q + SlotW'(1);
      end
    end
  end

  always_comb begin
    case (ctl_i.frame_sel)
      FRM_SCAN:  frame_mux = 4'(scan_q);
      FRM_TABLE: frame_mux = 4'(pt_rd_q);
      default:   frame_mux = 4'd0;
    endcase
    case (ctl_i.slot_sel)
      SLT_COUNT: slot_mux = slot_q;
      SLT_INDEX: slot_mux = idx_q;
      default:   slot_mux = '0;
    endcase
  end

  // The free count is settled before the first beat of an allocation goes out.
  always_ff @(posedge clk_i) begin
    if (ctl_i.emit) begin
      out_q.status     <= ctl_i.status;
      out_q.frame      <= frame_mux;
      out_q.page_slot  <= slot_mux;
      out_q.free_count <= 5'(frees_q);
      out_q.last       <= ctl_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (ctl_i.emit) begin
      out_vld_q <= 1'b1;
    end else if (res_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  assign res_valid_o = out_vld_q;
  assign res_data_o  = out_q;

  always_comb begin
    sts_o.req_bad     = (int'(pid_q) >= MAX_PROCS)
                      || (cmd_q != CMD_ALLOC && cmd_q != CMD_FREE && cmd_q != CMD_READ);
    sts_o.is_alloc    = (cmd_q == CMD_ALLOC);
    sts_o.is_free     = (cmd_q == CMD_FREE);
    sts_o.alloc_bad   = (num_q == 4'd0) || (int'(num_q) > PAGES_PER_PROC)
                      || (int'(num_q) > MaxRes) || (held_now != '0);
    sts_o.alloc_short = int'(num_q) > int'(frees_q);
    sts_o.held_zero   = (held_now == '0);
    sts_o.idx_bad     = int'(idx_q) >= PAGES_PER_PROC;
    sts_o.entry_valid = {1'b0, idx_q} < held_now;
    sts_o.scan_free   = free_map_q[scan_q];
    sts_o.alloc_last  = ({1'b0, slot_q} + 4'd1) == num_q;
    sts_o.free_last   = ({1'b0, slot_q} + 4'd1) == held_now;
    sts_o.out_room    = out_room;
  end

endmodule

// ===== hdl/page_frame_allocator.sv =====
// Bitmap page frame allocator. Each request beat gives one or more result beats,
// the final one marked by last. A request is taken in the idle state and then
// checked in the check state. An allocate then scans the free bitmap one frame a
// cycle, stalling at a free frame while the beat in the output register is not
// taken, and emits one beat per frame it hands out; the scan restarts at frame
// zero for each request. A free of a process that holds pages reads the page
// table for each page and then updates the bitmap, and then emits its result. A
// read of a valid entry reads the page table in the check state and then emits
// the entry; rejected requests, reads of invalid entries and frees of a process
// that holds nothing are answered from the check state. No clearing pass is
// needed after reset. A new request is taken once the previous one has been
// handed to the output register, even if that result beat is still waiting to
// be taken.
module page_frame_allocator #(
  parameter int NUM_FRAMES     = pfa_pkg::NumFramesDef,
  parameter int MAX_PROCS      = pfa_pkg::MaxProcsDef,
  parameter int PAGES_PER_PROC = pfa_pkg::PagesPerProcDef
) (
  input logic      clk_i,
  input logic      rst_ni,
  pfa_req_if.sink  req_i,
  pfa_res_if.source res_o
);
  import pfa_pkg::*;

  pfa_ctl_t ctl;
  pfa_sts_t sts;
  logic     req_ready;

  pfa_ctrl u_pfa_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  pfa_datapath #(
    .NUM_FRAMES     (NUM_FRAMES),
    .MAX_PROCS      (MAX_PROCS),
    .PAGES_PER_PROC (PAGES_PER_PROC)
  ) u_pfa_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_data_i  (req_i.payload),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .res_valid_o (res_o.valid),
    .res_data_o  (res_o.payload),
    .res_ready_i (res_o.ready)
  );

  assign req_i.ready = req_ready;

endmodule

// ===== hdl/pfa_checker.sv =====
`include "page_frame_allocator_macros.svh"

module pfa_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          req_valid_i,
  input logic          req_ready_i,
  input logic          res_valid_i,
  input logic          res_ready_i,
  input pfa_pkg::res_t res_data_i
);
  import pfa_pkg::*;

  `PFA_ASSERT_NEXT(res_hold_a, res_valid_i && !res_ready_i, res_valid_i && $stable(res_data_i), "stalled result beat was dropped or changed")

  // The block is busy for at least the cycle after a request beat.
  `PFA_ASSERT_NEXT(busy_after_req_a, req_valid_i && req_ready_i, !req_ready_i, "request taken while the previous one was being checked")

  // Refusals and invalid entries are single beats that carry no frame.
  `PFA_ASSERT_NOW(fail_single_a, res_valid_i && res_data_i.status != ST_OK, res_data_i.last && res_data_i.frame == 4'd0, "failing result not a single beat with frame zero")

  // Only a successful allocation spreads over several beats.
  `PFA_ASSERT_NOW(multi_ok_a, res_valid_i && !res_data_i.last, res_data_i.status == ST_OK, "non-final result beat with a failing status")

endmodule

bind page_frame_allocator pfa_checker u_pfa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_data_i  (res_o.payload)
);

// ===== tb/tb_page_frame_allocator.sv =====
`timescale 1ns / 1ps

module tb_page_frame_allocator;
  import pfa_pkg::*;

  localparam int NumFrames    = NumFramesDef;
  localparam int MaxProcs     = MaxProcsDef;
  localparam int PagesPerProc = PagesPerProcDef;
  localparam int ReqW         = $bits(req_t);
  localparam logic [1:0] CmdUnused = 2'd3;
  localparam int StallLimit = 5000;
  localparam int HoldOffCycles = 300;
  localparam int RandomPerPhase = 50;

  class frame_alloc_scoreboard;
    bit [NumFrames-1:0] free_map;
    int                 free_left;
    bit                 page_valid[MaxProcs*PagesPerProc];
    bit [3:0]           page_frame[MaxProcs*PagesPerProc];
    int                 held[MaxProcs];
    res_t               expected_beats[$];
    int                 mismatches;
    int                 beats_checked;
    int                 granted, short_cnt, bad_cnt, free_cnt, read_cnt, invalid_cnt;

    function new();
      free_map  = '1;
      free_left = NumFrames;
      foreach (page_valid[i]) begin
        page_valid[i] = 1'b0;
        page_frame[i] = '0;
      end
      foreach (held[i]) held[i] = 0;
    endfunction

    // Works out the result beats of one accepted request and updates the state.
    function void note_request(req_t r);
      res_t e;
      int   base;
      int   f;
      int   n;
      int   taken[MaxRes];

      e = '0;
      e.last = 1'b1;
      n = r.num_pages;
      if (r.pid >= MaxProcs || r.cmd == CmdUnused) begin
        e.status = ST_BAD_REQ;
        e.free_count = 5'(free_left);
        expected_beats.push_back(e);
        bad_cnt++;
        return;
      end
      base = r.pid * PagesPerProc;
      case (r.cmd)
        CMD_ALLOC: begin
          if (n == 0 || n > PagesPerProc || n > MaxRes || held[r.pid] != 0) begin
            e.status = ST_BAD_REQ;
            bad_cnt++;
          end else if (n > free_left) begin
            e.status = ST_NO_FRAMES;
            short_cnt++;
          end else begin
            for (int i = 0; i < n; i++) begin
              f = 0;
              for (int k = NumFrames - 1; k >= 0; k--) if (free_map[k]) f = k;
              free_map[f] = 1'b0;
              free_left--;
              page_valid[base + i] = 1'b1;
              page_frame[base + i] = 4'(f);
              taken[i] = f;
            end
            held[r.pid] = n;
            granted++;
            for (int i = 0; i < n; i++) begin
              e.status     = ST_OK;
              e.frame      = 4'(taken[i]);
              e.page_slot  = 3'(i);
              e.free_count = 5'(free_left);
              e.last       = (i == n - 1);
              expected_beats.push_back(e);
            end
            return;
          end
        end
        CMD_FREE: begin
          for (int i = 0; i < held[r.pid] && i < PagesPerProc; i++) begin
            if (page_valid[base + i]) begin
              f = page_frame[base + i];
              if (f < NumFrames && !free_map[f]) begin
                free_map[f] = 1'b1;
                free_left++;
              end
              page_valid[base + i] = 1'b0;
              page_frame[base + i] = '0;
            end
          end
          held[r.pid] = 0;
          e.status = ST_OK;
          free_cnt++;
        end
        default: begin
          e.page_slot = r.page_index;
          read_cnt++;
          if (r.page_index >= PagesPerProc) begin
            e.status = ST_BAD_REQ;
          end else if (!page_valid[base + r.page_index]) begin
            e.status = ST_INVALID;
            invalid_cnt++;
          end else begin
            e.status = ST_OK;
            e.frame  = page_frame[base + r.page_index];
          end
        end
      endcase
      e.free_count = 5'(free_left);
      expected_beats.push_back(e);
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(res_t got);
      res_t want;
      beats_checked++;
      if (expected_beats.size() == 0) begin
        report($sformatf("result beat %p arrived with nothing outstanding", got));
        return;
      end
      want = expected_beats.pop_front();
      if (got.status != want.status)
        report($sformatf("status %0d, wanted %0d", got.status, want.status));
      if (got.frame != want.frame)
        report($sformatf("frame %0d, wanted %0d", got.frame, want.frame));
      if (got.page_slot != want.page_slot)
        report($sformatf("page_slot %0d, wanted %0d", got.page_slot, want.page_slot));
      if (got.free_count != want.free_count)
        report($sformatf("free_count %0d, wanted %0d", got.free_count, want.free_count));
      if (got.last != want.last)
        report($sformatf("last %0b, wanted %0b", got.last, want.last));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  pfa_req_if req_if ();
  pfa_res_if res_if ();

  page_frame_allocator DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .res_o (res_if)
  );

  frame_alloc_scoreboard sb = new();

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int requests_sent = 0;

  always #5 clk_i = ~clk_i;

  // Result side: take beats, then choose ready for the next edge.
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if (res_if.valid && res_if.ready) sb.check_result(res_if.payload);
        if (hold_left > 0) begin
          hold_left--;
          res_if.ready <= 1'b0;
        end else begin
          res_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("watchdog: no beat moved for %0d cycles", StallLimit);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic req_t mk(logic [1:0] cmd, int pid, int n, int idx);
    req_t r;
    r.cmd        = cmd;
    r.pid        = 4'(pid);
    r.num_pages  = 4'(n);
    r.page_index = 3'(idx);
    return r;
  endfunction

  task automatic send_req(input req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.payload <= r;
    req_if.valid   <= 1'b1;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sb.note_request(r);
    requests_sent++;
  endtask

  // Mostly well-formed traffic aimed at processes in a useful state, with some noise.
  function automatic req_t make_item();
    req_t r;
    int   pick;
    int   most;
    int   holders[$];
    int   empties[$];

    r = req_t'(ReqW'($urandom));
    for (int p = 0; p < MaxProcs; p++) begin
      if (sb.held[p] != 0) holders.push_back(p);
      else empties.push_back(p);
    end
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      r.cmd = CMD_ALLOC;
      if (empties.size() > 0 && $urandom_range(0, 9) < 8)
        r.pid = 4'(empties[$urandom_range(0, empties.size() - 1)]);
      if ($urandom_range(0, 9) < 8) begin
        most = (sb.free_left < MaxRes) ? sb.free_left : MaxRes;
        if (most < 1) most = 1;
        // Small requests leave frames for several processes to hold pages at once.
        if ($urandom_range(0, 3) != 0 && most > 4) most = 4;
        r.num_pages = 4'($urandom_range(1, most));
      end
    end else if (pick < 65) begin
      r.cmd = CMD_FREE;
      if (holders.size() > 0 && $urandom_range(0, 9) < 8)
        r.pid = 4'(holders[$urandom_range(0, holders.size() - 1)]);
    end else if (pick < 95) begin
      r.cmd = CMD_READ;
      if (holders.size() > 0 && $urandom_range(0, 9) < 8)
        r.pid = 4'(holders[$urandom_range(0, holders.size() - 1)]);
    end else begin
      r.cmd = CmdUnused;
    end
    return r;
  endfunction

  initial begin
    req_if.valid   <= 1'b0;
    req_if.payload <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: rejections, a full memory, fragmentation and a clean-up.
    send_req(mk(CMD_READ, 0, 0, 0));
    send_req(mk(CMD_FREE, 0, 0, 0));
    send_req(mk(CMD_ALLOC, 0, 0, 0));
    send_req(mk(CMD_ALLOC, 0, 15, 7));
    send_req(mk(CMD_ALLOC, 0, 9, 0));
    send_req(mk(CmdUnused, 15, 15, 7));
    send_req(mk(CMD_ALLOC, 0, 8, 0));
    send_req(mk(CMD_ALLOC, 0, 1, 0));
    send_req(mk(CMD_ALLOC, 15, 8, 0));
    send_req(mk(CMD_ALLOC, 1, 1, 0));
    send_req(mk(CMD_READ, 15, 0, 7));
    send_req(mk(CMD_READ, 0, 0, 0));
    send_req(mk(CMD_FREE, 0, 0, 0));
    send_req(mk(CMD_READ, 0, 0, 3));
    send_req(mk(CMD_ALLOC, 3, 3, 0));
    send_req(mk(CMD_ALLOC, 5, 6, 0));
    send_req(mk(CMD_ALLOC, 5, 5, 0));
    send_req(mk(CMD_FREE, 3, 0, 0));
    send_req(mk(CMD_ALLOC, 7, 2, 0));
    send_req(mk(CMD_READ, 7, 0, 1));
    send_req(mk(CMD_FREE, 15, 0, 0));
    send_req(mk(CMD_FREE, 5, 0, 0));
    send_req(mk(CMD_FREE, 7, 0, 0));

    // The result side holds off for a long stretch while requests keep coming.
    hold_left = HoldOffCycles;
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1) ? 57 : (phase == 3) ? 26 : 0;
      recv_stall_pct = (phase == 2) ? 57 : (phase == 3) ? 26 : 0;
      repeat (RandomPerPhase) send_req(make_item());
    end
    req_if.valid <= 1'b0;

    while (sb.expected_beats.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Covered %0d requests: %0d allocations granted, %0d short of frames, %0d rejected,",
             requests_sent, sb.granted, sb.short_cnt, sb.bad_cnt);
    $display("%0d frees and %0d reads (%0d of invalid entries); %0d result beats checked.",
             sb.free_cnt, sb.read_cnt, sb.invalid_cnt, sb.beats_checked);
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
